FILE: hdl/fat_cluster_chain_allocator_assert.svh
// Assertion macros used by the allocator sequencer (fcca_ctrl).
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcca assertion failed");

// Next-cycle implication, disabled during reset.
`define FCCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcca assertion failed");

`endif

FILE: hdl/fcca_pkg.sv
`default_nettype none

package fcca_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 4096;
   localparam int unsigned CLUSTER_W = 12;
   localparam int unsigned VALUE_W   = 28;

   // Entry values (top four bits are never set, so only 28 bits are stored)
   localparam logic [VALUE_W-1:0] END_MARK  = 28'hFFFFFF8;
   localparam logic [CLUSTER_W-1:0] LAST_CLUSTER_RESET = 12'hFFF;

   // Operation codes
   localparam logic [1:0] OP_LOOKUP       = 2'd0;
   localparam logic [1:0] OP_WRITE        = 2'd1;
   localparam logic [1:0] OP_ALLOC        = 2'd2;
   localparam logic [1:0] OP_ALLOC_LOOKUP = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]           operation;
      logic [CLUSTER_W-1:0] cluster_number;
      logic [VALUE_W-1:0]   entry_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] result_cluster;
      logic [1:0]         status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/fat_cluster_chain_allocator.sv
`default_nettype none

// FAT cluster table allocator.
// Request channel (req_valid/req_ready, req_payload) carries one transaction:
// lookup, write, allocate, or allocate-or-lookup on a 12-bit cluster number.
// Response channel (rsp_valid/rsp_ready, rsp_payload) returns exactly one
// transaction per request: result cluster and status.
// csr_write_enable/csr_write_data set last_cluster_number (reset 4095), the
// upper bound of the free-entry scan; write it only while the block is idle.
// After reset a clearing pass zeroes the table, one entry per cycle;
// req_ready stays low during it.
// Range errors and writes go from acceptance through the execute state to
// the done state; lookups add a read-wait state. Allocation scans one entry
// per cycle through the single RAM read port, then writes the end mark and,
// for a nonzero link cluster, the link entry; allocate-or-lookup first reads
// the entry and scans only when it holds an end-of-chain mark.
// One transaction is in flight at a time; the next request can be accepted
// from the cycle in which rsp_valid rises.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is accepted and worked on, which then waits to emit
// until rsp_ready.
module fat_cluster_chain_allocator #(
   parameter int unsigned TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire fcca_pkg::req_type                req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fcca_pkg::rsp_type                     rsp_payload,
   input  wire logic                             csr_write_enable,
   input  wire logic [fcca_pkg::CLUSTER_W-1:0]   csr_write_data
);

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned XW =
      ((AW > fcca_pkg::CLUSTER_W) ? AW : fcca_pkg::CLUSTER_W) + 1;
   localparam logic [XW-1:0] TOP_CLU = XW'(TABLE_ENTRIES - 1);

   logic [fcca_pkg::CLUSTER_W-1:0] last_ff, last_in;
   logic [XW-1:0]                  last_x;
   logic [XW-1:0]                  scan_limit;

   logic                           mem_wr_en;
   logic [AW-1:0]                  mem_wr_addr;
   logic [fcca_pkg::VALUE_W-1:0]   mem_wr_data;
   logic                           mem_rd_en;
   logic [AW-1:0]                  mem_rd_addr;
   logic [fcca_pkg::VALUE_W-1:0]   mem_rd_data;

   // Scan limit register, clamped to the table
   assign last_in    = csr_write_enable ? csr_write_data : last_ff;
   assign last_x     = XW'(last_ff);
   assign scan_limit = (last_x > TOP_CLU) ? TOP_CLU : last_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= fcca_pkg::LAST_CLUSTER_RESET;
      end else begin
         last_ff <= last_in;
      end
   end

   fcca_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .scan_limit  (scan_limit),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   fcca_ram #(
      .WIDTH (fcca_pkg::VALUE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

FILE: hdl/fcca_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fcca_ram #(
   parameter int unsigned WIDTH = 28,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/fcca_ctrl.sv
`default_nettype none

// Sequencer: clearing pass, operation decode, one-entry-per-cycle free scan,
// table updates and the response register.
module fcca_ctrl #(
   parameter int unsigned TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int unsigned AW = $clog2(TABLE_ENTRIES),
   localparam int unsigned XW = ((AW > fcca_pkg::CLUSTER_W) ? AW : fcca_pkg::CLUSTER_W) + 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire fcca_pkg::req_type          req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output fcca_pkg::rsp_type               rsp_payload,
   input  wire logic [XW-1:0]              scan_limit,
   output logic                            mem_wr_en,
   output logic [AW-1:0]                   mem_wr_addr,
   output logic [fcca_pkg::VALUE_W-1:0]    mem_wr_data,
   output logic                            mem_rd_en,
   output logic [AW-1:0]                   mem_rd_addr,
   input  wire logic [fcca_pkg::VALUE_W-1:0] mem_rd_data
);

`include "fat_cluster_chain_allocator_assert.svh"

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_RDWT  = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_MARK  = 3'd5;
   localparam logic [2:0] S_LINK  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
   localparam logic [XW-1:0] ENTRIES_X = XW'(TABLE_ENTRIES);
   localparam logic [XW-1:0] FIRST_CLU = XW'(2);

   logic [2:0]                       state_ff, state_in;
   logic [AW-1:0]                    clr_ff, clr_in;
   logic [1:0]                       op_ff, op_in;
   logic [fcca_pkg::CLUSTER_W-1:0]   clu_ff, clu_in;
   logic [fcca_pkg::VALUE_W-1:0]     val_ff, val_in;
   logic [XW-1:0]                    scan_ff, scan_in;
   logic [XW-1:0]                    rdc_ff, rdc_in;
   logic                             rdv_ff, rdv_in;
   logic [fcca_pkg::VALUE_W-1:0]     res_ff, res_in;
   logic [1:0]                       st_ff, st_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   fcca_pkg::rsp_type                rsp_ff, rsp_in;

   logic          in_table;
   logic          link_bad;
   logic          can_emit;
   logic          emit;
   logic [AW-1:0] clu_addr;
   logic [AW-1:0] fnd_addr;

   assign in_table = (clu_ff >= fcca_pkg::CLUSTER_W'(2)) && (XW'(clu_ff) < ENTRIES_X);
   assign link_bad = (clu_ff != '0) && !in_table;
   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign clu_addr = AW'(clu_ff);
   assign fnd_addr = AW'(rdc_ff);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      clu_in      = clu_ff;
      val_in      = val_ff;
      scan_in     = scan_ff;
      rdc_in      = rdc_ff;
      rdv_in      = rdv_ff;
      res_in      = res_ff;
      st_in       = st_ff;
      emit        = 1'b0;
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clu_addr;
      mem_wr_data = val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = clu_addr;

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_payload.operation;
               clu_in   = req_payload.cluster_number;
               val_in   = req_payload.entry_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            scan_in = FIRST_CLU;
            rdv_in  = 1'b0;
            res_in  = '0;
            st_in   = fcca_pkg::ST_OK;
            unique case (op_ff)
               fcca_pkg::OP_ALLOC: begin
                  if (link_bad) begin
                     st_in    = fcca_pkg::ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               fcca_pkg::OP_WRITE: begin
                  if (!in_table) begin
                     st_in = fcca_pkg::ST_RANGE;
                  end else begin
                     mem_wr_en = 1'b1;
                  end
                  state_in = S_DONE;
               end
               default: begin
                  if (!in_table) begin
                     st_in    = fcca_pkg::ST_RANGE;
                     state_in = S_DONE;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = S_RDWT;
                  end
               end
            endcase
         end
         S_RDWT: begin
            if ((op_ff == fcca_pkg::OP_ALLOC_LOOKUP) && (mem_rd_data >= fcca_pkg::END_MARK)) begin
               state_in = S_SCAN;
            end else begin
               res_in   = mem_rd_data;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            // issue one read per cycle; data for rdc_ff arrives this cycle
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(scan_ff);
            rdv_in      = (scan_ff <= scan_limit);
            rdc_in      = scan_ff;
            scan_in     = scan_ff + XW'(1);
            if (rdv_ff && (mem_rd_data == '0)) begin
               // keep the address of the free entry for the mark and link writes
               rdc_in   = rdc_ff;
               state_in = S_MARK;
            end else if (!rdv_ff && (scan_ff > scan_limit)) begin
               res_in   = '0;
               st_in    = fcca_pkg::ST_FULL;
               state_in = S_DONE;
            end
         end
         S_MARK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = fnd_addr;
            mem_wr_data = fcca_pkg::END_MARK;
            res_in      = fcca_pkg::VALUE_W'(rdc_ff);
            st_in       = fcca_pkg::ST_OK;
            state_in    = (clu_ff != '0) ? S_LINK : S_DONE;
         end
         S_LINK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clu_addr;
            mem_wr_data = fcca_pkg::VALUE_W'(rdc_ff);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (can_emit) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.result_cluster = res_ff;
         rsp_in.status         = st_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      clu_ff  <= clu_in;
      val_ff  <= val_in;
      scan_ff <= scan_in;
      rdc_ff  <= rdc_in;
      res_ff  <= res_in;
      st_ff   <= st_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Checks
   `FCCA_ASSERT_SAME(a_no_rsp_in_clear, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff)
   `FCCA_ASSERT_SAME(a_no_write_while_scan, clock, reset,
      (state_ff == S_SCAN) || (state_ff == S_IDLE) || (state_ff == S_DONE), !mem_wr_en)
   `FCCA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready,
      state_ff == S_EXEC)
   `FCCA_ASSERT_NEXT(a_emit_sets_valid, clock, reset, emit, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: test/tb_fat_cluster_chain_allocator.sv
`timescale 1ns / 1ps

module tb_fat_cluster_chain_allocator;

   localparam int TABLE_SIZE   = fcca_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int CW           = fcca_pkg::CLUSTER_W;
   localparam int VW           = fcca_pkg::VALUE_W;
   localparam int LIMIT_CYCLES = 2_500_000;
   localparam int PHASE_ITEMS  = 16;
   localparam int HOLD_AFTER   = 30;
   localparam int HOLD_CYCLES  = 400;

   // Shadow of the cluster table: predicts each response and checks it in order
   class cluster_table_shadow;
      logic [VW-1:0]       entries [TABLE_SIZE];
      logic [CW-1:0]       scan_limit;
      logic [CW-1:0]       newest_cluster;
      fcca_pkg::rsp_type   expected_q [$];
      int errors;
      int checked;
      int alloc_count;
      int full_count;
      int range_count;

      function new();
         foreach (entries[i]) entries[i] = '0;
         scan_limit     = fcca_pkg::LAST_CLUSTER_RESET;
         newest_cluster = CW'(2);
      endfunction

      function bit in_table(logic [CW-1:0] c);
         return c >= 2 && c < TABLE_SIZE;
      endfunction

      // First free entry from 2 up to the scan limit; marks it end-of-chain and writes the link
      function logic [VW-1:0] claim_free(logic [CW-1:0] link);
         int top;
         top = scan_limit;
         if (top > TABLE_SIZE - 1) top = TABLE_SIZE - 1;
         for (int c = 2; c <= top; c++) begin
            if (entries[c] == '0) begin
               entries[c] = fcca_pkg::END_MARK;
               // self link overwrites the end mark just set
               if (link != '0) entries[link] = VW'(c);
               newest_cluster = CW'(c);
               alloc_count++;
               return VW'(c);
            end
         end
         full_count++;
         return '0;
      endfunction

      function void note_request(fcca_pkg::req_type r);
         fcca_pkg::rsp_type e;
         logic [VW-1:0]     next;
         e.result_cluster = '0;
         e.status         = fcca_pkg::ST_OK;
         if (r.operation == fcca_pkg::OP_ALLOC) begin
            // link 0 means no link; any other link must be in the table
            if (r.cluster_number != '0 && !in_table(r.cluster_number)) begin
               e.status = fcca_pkg::ST_RANGE;
            end else begin
               e.result_cluster = claim_free(r.cluster_number);
               if (e.result_cluster == '0) e.status = fcca_pkg::ST_FULL;
            end
         end else if (!in_table(r.cluster_number)) begin
            e.status = fcca_pkg::ST_RANGE;
         end else begin
            case (r.operation)
               fcca_pkg::OP_LOOKUP: begin
                  e.result_cluster = entries[r.cluster_number];
               end
               fcca_pkg::OP_WRITE: begin
                  entries[r.cluster_number] = r.entry_value;
               end
               fcca_pkg::OP_ALLOC_LOOKUP: begin
                  // end-of-chain extends the chain, a free entry just reads 0
                  next = entries[r.cluster_number];
                  if (next >= fcca_pkg::END_MARK) begin
                     e.result_cluster = claim_free(r.cluster_number);
                     if (e.result_cluster == '0) e.status = fcca_pkg::ST_FULL;
                  end else begin
                     e.result_cluster = next;
                  end
               end
               default: ;
            endcase
         end
         if (e.status == fcca_pkg::ST_RANGE) range_count++;
         expected_q.push_back(e);
      endfunction

      function void check_response(fcca_pkg::rsp_type a);
         fcca_pkg::rsp_type e;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual cluster %0h status %0d",
                     $time, a.result_cluster, a.status);
            return;
         end
         e = expected_q.pop_front();
         if (a.result_cluster !== e.result_cluster) begin
            errors++;
            $display("%0t: result_cluster mismatch: expected %0h, actual %0h",
                     $time, e.result_cluster, a.result_cluster);
         end
         if (a.status !== e.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, e.status, a.status);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   fcca_pkg::req_type req_payload      = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   fcca_pkg::rsp_type rsp_payload;
   logic              csr_write_enable = 1'b0;
   logic [CW-1:0]     csr_write_data   = '0;

   cluster_table_shadow sb = new();
   int calm_req = 0;
   int calm_rsp = 0;
   int limits_used = 0;

   fat_cluster_chain_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle cycles before the next transaction; now and then a run of no idling
   function automatic int draw_gap(input bit for_rsp);
      int calm;
      calm = for_rsp ? calm_rsp : calm_req;
      if (calm > 0) begin
         calm--;
      end else if ($urandom_range(0, 11) == 0) begin
         calm = $urandom_range(5, 15);
      end
      if (for_rsp) calm_rsp = calm;
      else calm_req = calm;
      return (calm > 0) ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic fcca_pkg::req_type make_req(logic [1:0] op, logic [CW-1:0] c,
                                                  logic [VW-1:0] v);
      fcca_pkg::req_type r;
      r.operation      = op;
      r.cluster_number = c;
      r.entry_value    = v;
      return r;
   endfunction

   // Mostly chain traffic on the newest cluster, the rest random noise
   function automatic fcca_pkg::req_type random_request();
      fcca_pkg::req_type r;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.entry_value = VW'($urandom_range(2, 48));
      else if (pick < 45) r.entry_value = '0;
      else if (pick < 60) r.entry_value = fcca_pkg::END_MARK + VW'($urandom_range(0, 7));
      else                r.entry_value = VW'($urandom_range(0, 28'hFFFFFFF));
      r.operation = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         if (r.operation == fcca_pkg::OP_WRITE) r.operation = fcca_pkg::OP_ALLOC_LOOKUP;
         r.cluster_number = sb.newest_cluster;
         if (r.operation == fcca_pkg::OP_ALLOC && $urandom_range(0, 3) == 0) begin
            r.cluster_number = '0;
         end
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 20)      r.cluster_number = CW'($urandom_range(0, 1));
         else if (pick < 45) r.cluster_number = CW'($urandom_range(0, 4095));
         else                r.cluster_number = CW'($urandom_range(2, 48));
      end
      return r;
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_request(input fcca_pkg::req_type r);
      int gap;
      gap = draw_gap(1'b0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   // Stop sending and wait until every expected response is back
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_scan_limit(input logic [CW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.scan_limit = value;
      limits_used++;
   endtask

   // Response side: random stalls, one long hold to back the block up
   initial begin : rsp_side
      int  gap;
      bit  held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && sb.checked == HOLD_AFTER) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap = draw_gap(1'b1);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_response(rsp_payload);
      end
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("tb_fat_cluster_chain_allocator: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [CW-1:0] limits [8];
      limits = '{12'd4, 12'd0, 12'd1, 12'd2, 12'd4095, 12'd40, 12'd2047, 12'd2};
      limits[7] = CW'($urandom_range(2, 64));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: bad clusters, self link, chains, end-of-chain extension
      send_request(make_req(fcca_pkg::OP_LOOKUP,       12'd0,    '0));
      send_request(make_req(fcca_pkg::OP_WRITE,        12'd1,    28'hFFFFFFF));
      send_request(make_req(fcca_pkg::OP_ALLOC_LOOKUP, 12'd0,    '0));
      send_request(make_req(fcca_pkg::OP_ALLOC,        12'd1,    '0));
      send_request(make_req(fcca_pkg::OP_ALLOC_LOOKUP, 12'd4095, '0));
      send_request(make_req(fcca_pkg::OP_ALLOC,        12'd2,    '0));
      send_request(make_req(fcca_pkg::OP_LOOKUP,       12'd2,    '0));
      send_request(make_req(fcca_pkg::OP_ALLOC,        12'd0,    '0));
      send_request(make_req(fcca_pkg::OP_ALLOC_LOOKUP, 12'd3,    '0));
      send_request(make_req(fcca_pkg::OP_LOOKUP,       12'd3,    '0));
      send_request(make_req(fcca_pkg::OP_WRITE,        12'd4095, 28'hFFFFFFF));
      send_request(make_req(fcca_pkg::OP_LOOKUP,       12'd4095, '0));
      send_request(make_req(fcca_pkg::OP_ALLOC_LOOKUP, 12'd4095, '0));
      send_request(make_req(fcca_pkg::OP_WRITE,        12'd2,    '0));
      send_request(make_req(fcca_pkg::OP_ALLOC,        12'd4095, '0));
      send_request(make_req(fcca_pkg::OP_WRITE,        12'd6,
                            fcca_pkg::END_MARK - 28'd1));
      send_request(make_req(fcca_pkg::OP_ALLOC_LOOKUP, 12'd6,    '0));
      send_request(make_req(fcca_pkg::OP_LOOKUP,       12'd4095, '0));

      // Random phases, each under its own scan limit
      foreach (limits[p]) begin
         drain_results(8);
         write_scan_limit(limits[p]);
         repeat (PHASE_ITEMS) send_request(random_request());
      end

      drain_results(20);
      $display("covered %0d transactions under %0d scan limits", sb.checked, limits_used);
      $display("allocations %0d, no-free answers %0d, range errors %0d",
               sb.alloc_count, sb.full_count, sb.range_count);
      if (sb.errors == 0) begin
         $display("tb_fat_cluster_chain_allocator: PASS");
      end else begin
         $display("tb_fat_cluster_chain_allocator: FAIL");
      end
      $finish;
   end

endmodule
